@@ sv/tcg_pkg.sv @@
// Package for the tracking costate gradient block: shared types, fixed-point
// constants, CORDIC arctangent table and rounding/saturation helpers.
// No dependencies; compiled first.
package tcg_pkg;

  // Q16.16 value and the wider Q30 CORDIC datapath word
  typedef logic signed [31:0] q16_t;
  typedef logic signed [33:0] cq_t;

  // Angle constants in Q16.16
  localparam logic signed [21:0] ANG_TWO_PI  = 22'sd411775;
  localparam logic signed [21:0] ANG_PI      = 22'sd205887;
  localparam logic signed [21:0] ANG_HALF_PI = 22'sd102944;
  localparam logic [18:0]        TWO_PI_U    = 19'd411775;

  // Reciprocal of 2pi for the modulo: quotient estimate is (h * RECIP) >> RECIP_SHIFT
  localparam int          RECIP_SHIFT = 41;
  localparam logic [23:0] ANG_RECIP   = 24'((64'd1 << RECIP_SHIFT) / 64'd411775);

  // CORDIC start vector (fixed gain, Q30) and a sanity bound on cos/sin in Q16.16
  localparam cq_t  GAIN_Q30   = 34'sd652032874;
  localparam q16_t UNIT_BOUND = 32'sd65600;

  // Divider: one pre stage, one quotient bit per stage, one post stage
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 2;

  // Saturation limits
  localparam q16_t Q_MAX = 32'sh7FFFFFFF;
  localparam q16_t Q_MIN = 32'sh80000000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_WEIGHT_ALONG   = 3'd0,
    REG_WEIGHT_LATERAL = 3'd1,
    REG_WEIGHT_HEADING = 3'd2,
    REG_WEIGHT_SPEED   = 3'd3,
    REG_REF_ALONG      = 3'd4,
    REG_REF_LATERAL    = 3'd5,
    REG_REF_HEADING    = 3'd6
  } reg_idx_t;

  // Per-item data carried alongside the sin/cos computation
  typedef struct packed {
    q16_t lat;
    q16_t v;
    q16_t ll;
    q16_t la;
    q16_t lh;
    q16_t k;
    q16_t e0;
    q16_t e1;
    q16_t e2;
    q16_t e3;
  } side_t;

  // Per-item data carried alongside the dividers
  typedef struct packed {
    q16_t d;
    logic fault;
    q16_t lls;
    q16_t llvc;
    q16_t w0e;
    q16_t w1e;
    q16_t w2e;
    q16_t w3e;
    q16_t thead;
    q16_t tspeed;
  } tail_t;

  // Truncated arctangent table, Q30
  function automatic cq_t atan_q30(input int unsigned i);
    case (i)
      0:  return 34'sh03243F6A8;
      1:  return 34'sh01DAC6705;
      2:  return 34'sh00FADBAFC;
      3:  return 34'sh007F56EA6;
      4:  return 34'sh003FEAB76;
      5:  return 34'sh001FFD55B;
      6:  return 34'sh000FFFAAA;
      7:  return 34'sh0007FFF55;
      8:  return 34'sh0003FFFEA;
      9:  return 34'sh0001FFFFD;
      10: return 34'sh0000FFFFF;
      11: return 34'sh00007FFFF;
      12: return 34'sh00003FFFF;
      13: return 34'sh00001FFFF;
      14: return 34'sh00000FFFF;
      15: return 34'sh000007FFF;
      16: return 34'sh000003FFF;
      17: return 34'sh000001FFF;
      18: return 34'sh000000FFF;
      19: return 34'sh0000007FF;
      20: return 34'sh0000003FF;
      21: return 34'sh0000001FF;
      22: return 34'sh0000000FF;
      23: return 34'sh00000007F;
      default: return 34'sh0;
    endcase
  endfunction

  // Full 64-bit signed product of two Q16.16 words
  function automatic logic signed [63:0] mul32(input q16_t a, input q16_t b);
    return 64'(a) * 64'(b);
  endfunction

  // Round a 64-bit product to Q16.16 (ties up) and saturate
  function automatic q16_t qrnd(input logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [47:0] sh;
    t  = p + 64'sd32768;
    sh = t[63:16];
    if (sh > 48'sd2147483647)       return Q_MAX;
    else if (sh < -48'sd2147483648) return Q_MIN;
    else                            return sh[31:0];
  endfunction

  // Saturate a widened sum to 32 bits
  function automatic q16_t sat34(input logic signed [33:0] v);
    if (v > 34'sd2147483647)       return Q_MAX;
    else if (v < -34'sd2147483648) return Q_MIN;
    else                           return v[31:0];
  endfunction

endpackage

@@ sv/tcg_cfg_if.sv @@
// Configuration write channel: register index and write data.
// No dependencies.
interface tcg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/tcg_in_if.sv @@
// Input item channel: path-frame state, costates, curvature and reference speed.
// No dependencies.
interface tcg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_along;
  logic signed [31:0] lateral_offset;
  logic signed [31:0] heading_error;
  logic signed [31:0] speed;
  logic signed [31:0] costate_along;
  logic signed [31:0] costate_lateral;
  logic signed [31:0] costate_heading;
  logic signed [31:0] path_curvature;
  logic signed [31:0] target_speed;

  modport source (output valid, output pos_along, output lateral_offset,
                  output heading_error, output speed, output costate_along,
                  output costate_lateral, output costate_heading,
                  output path_curvature, output target_speed, input ready);
  modport sink (input valid, input pos_along, input lateral_offset,
                input heading_error, input speed, input costate_along,
                input costate_lateral, input costate_heading,
                input path_curvature, input target_speed, output ready);
endinterface

@@ sv/tcg_out_if.sv @@
// Result channel: Hamiltonian gradient over the state and the denominator fault.
// No dependencies.
interface tcg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] grad_along;
  logic signed [31:0] grad_lateral;
  logic signed [31:0] grad_heading;
  logic signed [31:0] grad_speed;
  logic               denom_fault;

  modport source (output valid, output grad_along, output grad_lateral,
                  output grad_heading, output grad_speed, output denom_fault,
                  input ready);
  modport sink (input valid, input grad_along, input grad_lateral,
                input grad_heading, input grad_speed, input denom_fault,
                output ready);
endinterface

@@ sv/tcg_div.sv @@
// Pipelined Q16.16 divider: (num * 65536) / den, truncated toward zero, saturated.
// One quotient bit per stage; all stages advance only on en. Depends on tcg_pkg.
module tcg_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic signed [31:0] quo
);
  import tcg_pkg::*;

  logic [31:0] rem [0:DIV_STEPS];
  logic [31:0] dv  [0:DIV_STEPS];
  logic [31:0] dm  [0:DIV_STEPS];
  logic [31:0] qq  [0:DIV_STEPS];
  logic        neg [0:DIV_STEPS];
  logic        ovf [0:DIV_STEPS];

  logic [31:0] nmag, dmag;
  logic        big;

  // Magnitudes; a quotient of 2^32 or more can only saturate
  always_comb begin
    nmag = num[31] ? (~num + 32'd1) : num;
    dmag = den[31] ? (~den + 32'd1) : den;
    big  = {16'd0, nmag} >= {dmag, 16'd0};
  end

  // Pre stage: upper dividend bits seed the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {16'd0, nmag[31:16]};
      dv[0]  <= {nmag[15:0], 16'd0};
      dm[0]  <= dmag;
      qq[0]  <= '0;
      neg[0] <= num[31] ^ den[31];
      ovf[0] <= big;
    end
  end

  // Restoring steps, one quotient bit each
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
    logic [32:0] t;
    logic        ge;
    always_comb begin
      t  = {rem[j-1], dv[j-1][31]};
      ge = t >= {1'b0, dm[j-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= ge ? 32'(t - {1'b0, dm[j-1]}) : t[31:0];
        dv[j]  <= {dv[j-1][30:0], 1'b0};
        dm[j]  <= dm[j-1];
        qq[j]  <= {qq[j-1][30:0], ge};
        neg[j] <= neg[j-1];
        ovf[j] <= ovf[j-1];
      end
    end
  end

  // Post stage: sign and saturation
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[DIV_STEPS]) begin
        if (ovf[DIV_STEPS] || qq[DIV_STEPS] > 32'h80000000) quo <= Q_MIN;
        else quo <= ~qq[DIV_STEPS] + 32'd1;
      end else begin
        if (ovf[DIV_STEPS] || qq[DIV_STEPS] > 32'h7FFFFFFF) quo <= Q_MAX;
        else quo <= qq[DIV_STEPS];
      end
    end
  end

endmodule

@@ sv/tracking_costate_gradient.sv @@
// Channel  | Modport | Transaction carries
// cfg      | sink    | register index, 32-bit write data (always ready)
// item     | sink    | state, costates, curvature, reference speed
// grad     | source  | four saturated gradients, denominator fault
//
// One item per cycle while the result is not stalled; each result passes through the
// unrolled CORDIC and two chained 34-stage dividers.
// Synchronous active-high reset clears valid bits and sets configuration registers to defaults.
// A stalled result freezes the whole pipeline; item.ready is low only while a valid result waits on grad.ready.
// Depends on tcg_pkg, the channel interfaces and tcg_div.
module tracking_costate_gradient #(
  parameter int CORDIC_STEPS = 16
) (
  input logic       clk,
  input logic       rst,
  tcg_cfg_if.sink   cfg,
  tcg_in_if.sink    item,
  tcg_out_if.source grad
);
  import tcg_pkg::*;

  localparam int CS   = CORDIC_STEPS + 5;    // sin/cos register
  localparam int RD   = CS + 7;              // divider numerators ready
  localparam int LAST = RD + 2 * DIV_LAT + 1; // output register

  // Configuration registers
  logic [30:0] w_along, w_lat, w_head, w_speed;
  q16_t        r_along, r_lat, r_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_along <= 31'd65536;
      w_lat   <= 31'd65536;
      w_head  <= 31'd65536;
      w_speed <= 31'd65536;
      r_along <= '0;
      r_lat   <= '0;
      r_head  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WEIGHT_ALONG:   w_along <= cfg.data[30:0];
        REG_WEIGHT_LATERAL: w_lat   <= cfg.data[30:0];
        REG_WEIGHT_HEADING: w_head  <= cfg.data[30:0];
        REG_WEIGHT_SPEED:   w_speed <= cfg.data[30:0];
        REG_REF_ALONG:      r_along <= cfg.data;
        REG_REF_LATERAL:    r_lat   <= cfg.data;
        REG_REF_HEADING:    r_head  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid bits
  logic            en;
  logic [LAST:0]   vld;

  assign en         = !vld[LAST] || grad.ready;
  assign item.ready = en;
  assign grad.valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAST-1:0], item.valid};
  end

  // Stage 0: capture, state errors against references
  side_t side [0:CS];
  q16_t  head0, head1, head2;

  always_ff @(posedge clk) begin
    if (en) begin
      head0   <= item.heading_error;
      side[0] <= '{
        lat: item.lateral_offset,
        v:   item.speed,
        ll:  item.costate_lateral,
        la:  item.costate_along,
        lh:  item.costate_heading,
        k:   item.path_curvature,
        e0:  sat34(34'(item.pos_along) - 34'(r_along)),
        e1:  sat34(34'(item.lateral_offset) - 34'(r_lat)),
        e2:  sat34(34'(item.heading_error) - 34'(r_head)),
        e3:  sat34(34'(item.speed) - 34'(item.target_speed))
      };
    end
  end

  for (genvar j = 1; j <= CS; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) side[j] <= side[j-1];
    end
  end

  // Stages 1-3: heading modulo 2pi by reciprocal multiply and correction
  logic signed [56:0] hm1;
  logic signed [39:0] qm2;
  logic signed [15:0] q_est;
  logic signed [39:0] diff3;
  logic signed [21:0] r_raw, r_fix, r3;

  assign q_est = hm1[56:41];

  always_comb begin
    diff3 = 40'(head2) - qm2;
    r_raw = diff3[21:0];
    if (r_raw < 0)                r_fix = r_raw + ANG_TWO_PI;
    else if (r_raw >= ANG_TWO_PI) r_fix = r_raw - ANG_TWO_PI;
    else                          r_fix = r_raw;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hm1   <= 57'(head0) * $signed({1'b0, ANG_RECIP});
      head1 <= head0;
      qm2   <= 40'(q_est) * $signed({1'b0, TWO_PI_U});
      head2 <= head1;
      r3    <= r_fix;
    end
  end

  // Stage 4: into [-pi, pi], then fold into [-pi/2, pi/2]
  logic signed [21:0] r1, r2;
  logic               fold;
  logic signed [33:0] z4;
  logic               neg [4:CS-1];

  always_comb begin
    r1 = (r3 > ANG_PI) ? (r3 - ANG_TWO_PI) : r3;
    if (r1 > ANG_HALF_PI) begin
      r2   = r1 - ANG_PI;
      fold = 1'b1;
    end else if (r1 < -ANG_HALF_PI) begin
      r2   = r1 + ANG_PI;
      fold = 1'b1;
    end else begin
      r2   = r1;
      fold = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z4     <= 34'(r2) <<< 14;
      neg[4] <= fold;
    end
  end

  // CORDIC rotation, one micro-rotation per stage
  cq_t cx [1:CORDIC_STEPS];
  cq_t cy [1:CORDIC_STEPS];
  cq_t cz [1:CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    cq_t xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = GAIN_Q30;
      assign yi = '0;
      assign zi = z4;
    end else begin : g_next
      assign xi = cx[i];
      assign yi = cy[i];
      assign zi = cz[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (zi >= 0) begin
          cx[i+1] <= xi - (yi >>> i);
          cy[i+1] <= yi + (xi >>> i);
          cz[i+1] <= zi - atan_q30(i);
        end else begin
          cx[i+1] <= xi + (yi >>> i);
          cy[i+1] <= yi - (xi >>> i);
          cz[i+1] <= zi + atan_q30(i);
        end
        neg[5+i] <= neg[4+i];
      end
    end
  end

  // Round to Q16.16, undo the fold
  cq_t  xr, yr, xs, ys;
  q16_t c_q, s_q;

  always_comb begin
    xr = (cx[CORDIC_STEPS] + 34'sd8192) >>> 14;
    yr = (cy[CORDIC_STEPS] + 34'sd8192) >>> 14;
    xs = neg[CS-1] ? -xr : xr;
    ys = neg[CS-1] ? -yr : yr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_q <= xs[31:0];
      s_q <= ys[31:0];
    end
  end

  // First products
  logic signed [63:0] p_klat, p_klh, p_vc, p_vs, p_lls, p_w0, p_w1, p_w2, p_w3;
  q16_t m1_la, m1_ll, m1_k, m1_c;

  always_ff @(posedge clk) begin
    if (en) begin
      p_klat <= mul32(side[CS].k, side[CS].lat);
      p_klh  <= mul32(side[CS].k, side[CS].lh);
      p_vc   <= mul32(side[CS].v, c_q);
      p_vs   <= mul32(side[CS].v, s_q);
      p_lls  <= mul32(side[CS].ll, s_q);
      p_w0   <= mul32($signed({1'b0, w_along}), side[CS].e0);
      p_w1   <= mul32($signed({1'b0, w_lat}), side[CS].e1);
      p_w2   <= mul32($signed({1'b0, w_head}), side[CS].e2);
      p_w3   <= mul32($signed({1'b0, w_speed}), side[CS].e3);
      m1_la  <= side[CS].la;
      m1_ll  <= side[CS].ll;
      m1_k   <= side[CS].k;
      m1_c   <= c_q;
    end
  end

  // Rounding of the first products
  q16_t klat, klh, vc, vs, lls, w0e, w1e, w2e, w3e;
  q16_t r1_la, r1_ll, r1_k, r1_c;

  always_ff @(posedge clk) begin
    if (en) begin
      klat  <= qrnd(p_klat);
      klh   <= qrnd(p_klh);
      vc    <= qrnd(p_vc);
      vs    <= qrnd(p_vs);
      lls   <= qrnd(p_lls);
      w0e   <= qrnd(p_w0);
      w1e   <= qrnd(p_w1);
      w2e   <= qrnd(p_w2);
      w3e   <= qrnd(p_w3);
      r1_la <= m1_la;
      r1_ll <= m1_ll;
      r1_k  <= m1_k;
      r1_c  <= m1_c;
    end
  end

  // Denominator and costate differences
  q16_t d2, a2, b2, a2_k, a2_vc, a2_vs, a2_c, a2_ll, a2_lls;
  q16_t a2_w0, a2_w1, a2_w2, a2_w3;
  logic fault2;
  q16_t d_next;

  assign d_next = sat34(34'sd65536 - 34'(klat));

  always_ff @(posedge clk) begin
    if (en) begin
      d2     <= d_next;
      fault2 <= (d_next == '0);
      a2     <= sat34(34'(r1_la) - 34'(klh));
      b2     <= sat34(34'(klh) - 34'(r1_la));
      a2_k   <= r1_k;
      a2_vc  <= vc;
      a2_vs  <= vs;
      a2_c   <= r1_c;
      a2_ll  <= r1_ll;
      a2_lls <= lls;
      a2_w0  <= w0e;
      a2_w1  <= w1e;
      a2_w2  <= w2e;
      a2_w3  <= w3e;
    end
  end

  // Second products
  logic signed [63:0] p_kvc, p_vsb, p_ca, p_llvc;
  q16_t  m3_a;
  tail_t m3_t;

  always_ff @(posedge clk) begin
    if (en) begin
      p_kvc  <= mul32(a2_k, a2_vc);
      p_vsb  <= mul32(a2_vs, b2);
      p_ca   <= mul32(a2_c, a2);
      p_llvc <= mul32(a2_ll, a2_vc);
      m3_a   <= a2;
      m3_t   <= '{d: d2, fault: fault2, lls: a2_lls, llvc: '0, w0e: a2_w0, w1e: a2_w1,
                  w2e: a2_w2, w3e: a2_w3, thead: '0, tspeed: '0};
    end
  end

  // Rounding of the second products
  q16_t  kvc, vsb3, ca3, r3_a;
  tail_t r3_t;

  always_ff @(posedge clk) begin
    if (en) begin
      kvc  <= qrnd(p_kvc);
      vsb3 <= qrnd(p_vsb);
      ca3  <= qrnd(p_ca);
      r3_a <= m3_a;
      r3_t <= '{d: m3_t.d, fault: m3_t.fault, lls: m3_t.lls, llvc: qrnd(p_llvc),
                w0e: m3_t.w0e, w1e: m3_t.w1e, w2e: m3_t.w2e, w3e: m3_t.w3e,
                thead: '0, tspeed: '0};
    end
  end

  // Third product for the lateral numerator
  logic signed [63:0] p_n;
  q16_t  m4_vsb, m4_ca;
  tail_t m4_t;

  always_ff @(posedge clk) begin
    if (en) begin
      p_n    <= mul32(kvc, r3_a);
      m4_vsb <= vsb3;
      m4_ca  <= ca3;
      m4_t   <= r3_t;
    end
  end

  q16_t  nlat, n_vsb, n_ca;
  tail_t n_t;

  always_ff @(posedge clk) begin
    if (en) begin
      nlat  <= qrnd(p_n);
      n_vsb <= m4_vsb;
      n_ca  <= m4_ca;
      n_t   <= m4_t;
    end
  end

  // First division round: all three terms over D
  q16_t q_lat1, q_head, q_speed;

  tcg_div u_div_lat1 (.clk(clk), .en(en), .num(nlat), .den(n_t.d), .quo(q_lat1));
  tcg_div u_div_head (.clk(clk), .en(en), .num(n_vsb), .den(n_t.d), .quo(q_head));
  tcg_div u_div_speed (.clk(clk), .en(en), .num(n_ca), .den(n_t.d), .quo(q_speed));

  tail_t tail_a [0:DIV_LAT-1];
  tail_t tail_b [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tail_a[0] <= n_t;
      tail_b[0] <= '{d: tail_a[DIV_LAT-1].d, fault: tail_a[DIV_LAT-1].fault,
                     lls: tail_a[DIV_LAT-1].lls, llvc: tail_a[DIV_LAT-1].llvc,
                     w0e: tail_a[DIV_LAT-1].w0e, w1e: tail_a[DIV_LAT-1].w1e,
                     w2e: tail_a[DIV_LAT-1].w2e, w3e: tail_a[DIV_LAT-1].w3e,
                     thead: q_head, tspeed: q_speed};
    end
  end

  for (genvar j = 1; j < DIV_LAT; j++) begin : g_tail
    always_ff @(posedge clk) begin
      if (en) begin
        tail_a[j] <= tail_a[j-1];
        tail_b[j] <= tail_b[j-1];
      end
    end
  end

  // Second division of the lateral term by D
  q16_t q_lat2;

  tcg_div u_div_lat2 (
    .clk(clk), .en(en), .num(q_lat1), .den(tail_a[DIV_LAT-1].d), .quo(q_lat2)
  );

  // Final sums; the D terms drop out on a zero denominator
  tail_t tf;
  q16_t  t_lat, t_head, t_speed;

  always_comb begin
    tf      = tail_b[DIV_LAT-1];
    t_lat   = tf.fault ? '0 : q_lat2;
    t_head  = tf.fault ? '0 : tf.thead;
    t_speed = tf.fault ? '0 : tf.tspeed;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grad.grad_along   <= tf.w0e;
      grad.grad_lateral <= sat34(34'(t_lat) + 34'(tf.w1e));
      grad.grad_heading <= sat34(34'(t_head) + 34'(tf.llvc) + 34'(tf.w2e));
      grad.grad_speed   <= sat34(34'(t_speed) + 34'(tf.lls) + 34'(tf.w3e));
      grad.denom_fault  <= tf.fault;
    end
  end

  // A held result freezes the valid bits of every stage
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    grad.valid && !grad.ready |=> $stable(vld))
    else $error("pipeline moved while output stalled");

  // Modulo correction lands in [0, 2pi)
  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (r3 >= 0) && (r3 < ANG_TWO_PI))
    else $error("heading modulo out of range");

  // Folded CORDIC angle stays within +-pi/2
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (z4 <= (34'(ANG_HALF_PI) <<< 14)) && (z4 >= -(34'(ANG_HALF_PI) <<< 14)))
    else $error("CORDIC start angle out of range");

  // Cosine and sine stay near the unit circle
  a_unit_circle: assert property (@(posedge clk) disable iff (rst)
    vld[CS] |-> (c_q <= UNIT_BOUND) && (c_q >= -UNIT_BOUND) &&
                (s_q <= UNIT_BOUND) && (s_q >= -UNIT_BOUND))
    else $error("sin/cos magnitude out of range");

endmodule
